>>> hdl/phni_pkg.sv
package phni_pkg;

   localparam logic [6:0] OP_LUI    = 7'b0110111;
   localparam logic [6:0] OP_AUIPC  = 7'b0010111;
   localparam logic [6:0] OP_JAL    = 7'b1101111;
   localparam logic [6:0] OP_BRANCH = 7'b1100011;
   localparam logic [6:0] OP_JALR   = 7'b1100111;
   localparam logic [6:0] OP_OPIMM  = 7'b0010011;
   localparam logic [6:0] OP_FENCE  = 7'b0001111;
   localparam logic [6:0] OP_SYSTEM = 7'b1110011;
   localparam logic [6:0] OP_LOAD   = 7'b0000011;
   localparam logic [6:0] OP_OP     = 7'b0110011;
   localparam logic [6:0] OP_STORE  = 7'b0100011;

   localparam logic [31:0] BUBBLE_WORD = 32'h0000_0033;
   localparam logic [31:0] ECALL_WORD  = 32'h0000_0073;
   localparam logic [4:0]  REG_X0      = 5'b00000;

   typedef enum logic [2:0] {
      CL_UNKNOWN,
      CL_U,
      CL_J,
      CL_B,
      CL_IAR,
      CL_LOAD,
      CL_R,
      CL_S
   } instr_class_type;

   typedef struct packed {
      logic [31:0] newest_word;
      logic        newest_bubble;
      logic [31:0] older_word;
      logic        older_bubble;
   } history_type;

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  bubbles;
   } item_type;

   function automatic instr_class_type classify(input logic [31:0] w);
      instr_class_type c;
      unique case (w[6:0])
         OP_LUI, OP_AUIPC:                     c = CL_U;
         OP_JAL:                               c = CL_J;
         OP_BRANCH:                            c = CL_B;
         OP_JALR, OP_OPIMM, OP_FENCE, OP_SYSTEM: c = CL_IAR;
         OP_LOAD:                              c = CL_LOAD;
         OP_OP:                                c = CL_R;
         OP_STORE:                             c = CL_S;
         default:                              c = CL_UNKNOWN;
      endcase
      return c;
   endfunction

   // RAW check of a dependent word against one earlier emitted word
   function automatic logic conflicts(input logic [31:0] src, input logic src_bub,
                                      input logic [31:0] dep);
      instr_class_type sc;
      instr_class_type dc;
      logic [4:0]      rd;
      logic            reads1;
      logic            reads2;
      sc     = classify(src);
      dc     = classify(dep);
      rd     = src[11:7];
      reads1 = (dc == CL_R) || (dc == CL_IAR) || (dc == CL_LOAD) ||
               (dc == CL_S) || (dc == CL_B);
      reads2 = (dc == CL_R) || (dc == CL_S) || (dc == CL_B);
      return !src_bub && (sc != CL_S) && (rd != REG_X0) && (dep != ECALL_WORD) &&
             ((reads1 && (rd == dep[19:15])) || (reads2 && (rd == dep[24:20])));
   endfunction

endpackage

>>> hdl/phni_hazard.sv
module phni_hazard
   import phni_pkg::*;
(
   input  logic [31:0] instr_word,
   input  history_type hist,
   input  logic        forwarding_on,
   output logic [1:0]  bubbles
);

   always_comb begin
      bubbles = 2'd0;
      priority if (classify(instr_word) == CL_J) begin
         bubbles = 2'd1;
      end else if (forwarding_on) begin
         // load-use is the only case forwarding cannot cover
         if (classify(hist.newest_word) == CL_LOAD &&
             conflicts(hist.newest_word, hist.newest_bubble, instr_word)) begin
            bubbles = 2'd1;
         end
      end else if (conflicts(hist.newest_word, hist.newest_bubble, instr_word)) begin
         bubbles = 2'd2;
      end else if (conflicts(hist.older_word, hist.older_bubble, instr_word)) begin
         bubbles = 2'd1;
      end else begin
         bubbles = 2'd0;
      end
   end

endmodule

>>> hdl/phni_emitter.sv
module phni_emitter
   import phni_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  item_type    item,
   output logic        ready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   item_type    pend_ff, pend_in;
   logic        pend_valid_ff, pend_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic        rsp_bub_ff, rsp_bub_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        out_free;
   logic        take;
   logic        pend_done;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign take      = pend_valid_ff && out_free;
   assign pend_done = take && (pend_ff.bubbles == 2'd0);
   assign ready     = !pend_valid_ff || pend_done;

   always_comb begin
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_bub_in    = rsp_bub_ff;
      rsp_last_in   = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = pend_valid_ff;
      end
      if (take) begin
         rsp_bub_in  = (pend_ff.bubbles != 2'd0);
         rsp_last_in = (pend_ff.bubbles == 2'd0);
         rsp_word_in = (pend_ff.bubbles != 2'd0) ? BUBBLE_WORD : pend_ff.word;
      end
      if (load) begin
         pend_in       = item;
         pend_valid_in = 1'b1;
      end else if (pend_done) begin
         pend_valid_in = 1'b0;
      end else if (take) begin
         pend_in.bubbles = pend_ff.bubbles - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rsp_word_ff <= rsp_word_in;
      rsp_bub_ff  <= rsp_bub_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tuser  = rsp_bub_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> hdl/pipeline_hazard_nop_inserter.sv
// RV32 hazard interlock: inserts bubble NOPs (add x0,x0,x0) ahead of instructions.
// req_* : one instruction word per request (tdata = instr_word).
// rsp_* : emitted words; tuser = is_bubble, tlast = marks the instruction itself.
// csr_* : forwarding_on bit, written whenever csr_wr_en is high.
// The bubble count (0, 1 or 2; always 1 for JAL) is decided when a request is
// taken, from the word and the two-entry emit history, which is updated at once.
// Each request then occupies the holding register while the output register shifts
// out its bubbles and then the word. A request reaches the output through the
// holding register, then the output register. A new request is taken in the cycle
// the holding register hands over its word, so hazard-free streams run at one word
// per cycle while rsp_tready stays high.
// When rsp_tready is low the output register and the holding register hold and
// req_tready drops once the holding register is occupied.
// Reset empties both registers, clears forwarding_on and fills the history with
// bubbles.
module pipeline_hazard_nop_inserter
   import phni_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,   // forwarding_on
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,     // [31:0] instr_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,     // [31:0] out_word
   output logic        rsp_tuser,     // [0] is_bubble
   output logic        rsp_tlast      // last_of_run
);

   history_type hist_ff, hist_in;
   logic        fwd_ff, fwd_in;
   logic [1:0]  bubbles;
   logic        accept;
   item_type    item;

   assign accept = req_tvalid && req_tready;

   phni_hazard u_hazard (
      .instr_word    (req_tdata),
      .hist          (hist_ff),
      .forwarding_on (fwd_ff),
      .bubbles       (bubbles)
   );

   always_comb begin
      fwd_in  = csr_wr_en ? csr_wr_data : fwd_ff;
      hist_in = hist_ff;
      if (accept) begin
         // bubbles ahead of the word become the older entry
         hist_in.newest_word   = req_tdata;
         hist_in.newest_bubble = 1'b0;
         hist_in.older_word    = (bubbles == 2'd0) ? hist_ff.newest_word : BUBBLE_WORD;
         hist_in.older_bubble  = (bubbles == 2'd0) ? hist_ff.newest_bubble : 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff  <= 1'b0;
         hist_ff <= '{newest_word: BUBBLE_WORD, newest_bubble: 1'b1,
                      older_word: BUBBLE_WORD, older_bubble: 1'b1};
      end else begin
         fwd_ff  <= fwd_in;
         hist_ff <= hist_in;
      end
   end

   assign item.word    = req_tdata;
   assign item.bubbles = bubbles;

   phni_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .item       (item),
      .ready      (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> test/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import phni_pkg::*;

   localparam int PREDICT     = -1;      // expectation comes from the predictor
   localparam int HOLD_CYCLES = 60;
   localparam int CYCLE_LIMIT = 200000;

   typedef enum logic [1:0] {
      CFG_KEEP,
      CFG_OFF,
      CFG_ON
   } fwd_step_type;

   typedef struct {
      fwd_step_type step;
      logic [31:0]  word;
      int           want;   // bubble count, or PREDICT
   } seq_row_type;

   typedef struct packed {
      logic [31:0] word;
      logic        bubble;
      logic        closes;
   } emit_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;     // [31:0] instr_word
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;     // [31:0] out_word
   logic        rsp_tuser;     // [0] is_bubble
   logic        rsp_tlast;

   // predictor state
   logic        fwd_cfg = 1'b0;
   history_type hist = '{BUBBLE_WORD, 1'b1, BUBBLE_WORD, 1'b1};

   emit_type    emit_q[$];
   int          want_q[$];
   seq_row_type dir_tab[$];

   bit          quiet    = 1'b0;
   bit          burst    = 1'b0;
   bit          hold_ask = 1'b0;
   int          errors   = 0;
   int          n_req    = 0;
   int          n_rsp    = 0;
   int          n_bub    = 0;
   int          n_cfg    = 0;
   int          cycles   = 0;

   pipeline_hazard_nop_inserter uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic instr_class_type kind_of(input logic [31:0] w);
      case (w[6:0])
         OP_LUI, OP_AUIPC:                        kind_of = CL_U;
         OP_JAL:                                  kind_of = CL_J;
         OP_BRANCH:                               kind_of = CL_B;
         OP_JALR, OP_OPIMM, OP_FENCE, OP_SYSTEM:  kind_of = CL_IAR;
         OP_LOAD:                                 kind_of = CL_LOAD;
         OP_OP:                                   kind_of = CL_R;
         OP_STORE:                                kind_of = CL_S;
         default:                                 kind_of = CL_UNKNOWN;
      endcase
   endfunction

   // does dep read the register that src writes
   function automatic bit raw_dep(input logic [31:0] src, input logic src_bub,
                                  input logic [31:0] dep);
      logic [4:0]      dst;
      instr_class_type dk;
      dst = src[11:7];
      dk  = kind_of(dep);
      if (src_bub || kind_of(src) == CL_S || dst == REG_X0 || dep == ECALL_WORD)
         return 1'b0;
      return ((dk inside {CL_R, CL_IAR, CL_LOAD, CL_S, CL_B}) && dst == dep[19:15]) ||
             ((dk inside {CL_R, CL_S, CL_B}) && dst == dep[24:20]);
   endfunction

   function automatic int stall_count(input logic [31:0] w);
      if (kind_of(w) == CL_J)
         return 1;
      if (fwd_cfg)
         return (kind_of(hist.newest_word) == CL_LOAD &&
                 raw_dep(hist.newest_word, hist.newest_bubble, w)) ? 1 : 0;
      if (raw_dep(hist.newest_word, hist.newest_bubble, w))
         return 2;
      if (raw_dep(hist.older_word, hist.older_bubble, w))
         return 1;
      return 0;
   endfunction

   function automatic void shift_history(input logic [31:0] w, input logic bub);
      hist.older_word    = hist.newest_word;
      hist.older_bubble  = hist.newest_bubble;
      hist.newest_word   = w;
      hist.newest_bubble = bub;
   endfunction

   always @(posedge clock) begin : scoreboard
      int       pred;
      int       nb;
      int       want;
      emit_type got;
      emit_type head;
      if (reset) begin
         fwd_cfg = 1'b0;
         hist    = '{BUBBLE_WORD, 1'b1, BUBBLE_WORD, 1'b1};
      end else begin
         if (csr_wr_en) begin
            fwd_cfg = csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            pred = stall_count(req_tdata);
            want = want_q.pop_front();
            nb   = (want == PREDICT) ? pred : want;
            for (int k = 0; k < pred; k++) shift_history(BUBBLE_WORD, 1'b1);
            shift_history(req_tdata, 1'b0);
            for (int k = 0; k < nb; k++)
               emit_q.insert(emit_q.size(), '{BUBBLE_WORD, 1'b1, 1'b0});
            emit_q.insert(emit_q.size(), '{req_tdata, 1'b0, 1'b1});
            n_req++;
            n_bub += nb;
         end
         if (rsp_tvalid && rsp_tready) begin
            n_rsp++;
            got = '{rsp_tdata, rsp_tuser, rsp_tlast};
            if (emit_q.size() == 0) begin
               $error("response %h with nothing expected", rsp_tdata);
               errors++;
            end else begin
               head = emit_q.pop_front();
               if (got.word !== head.word) begin
                  $error("out_word: expected %h, got %h", head.word, got.word);
                  errors++;
               end
               if (got.bubble !== head.bubble) begin
                  $error("is_bubble: expected %b, got %b", head.bubble, got.bubble);
                  errors++;
               end
               if (got.closes !== head.closes) begin
                  $error("last_of_run: expected %b, got %b", head.closes, got.closes);
                  errors++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic logic [31:0] rv_word(input logic [6:0] op, input logic [4:0] rd,
                                           input logic [4:0] rs1, input logic [4:0] rs2);
      return {7'b0, rs2, rs1, 3'b0, rd, op};
   endfunction

   function automatic void add_row(input fwd_step_type step, input logic [31:0] word,
                                   input int want);
      seq_row_type row;
      row = '{step, word, want};
      dir_tab.insert(dir_tab.size(), row);
   endfunction

   // mostly well-formed words over a few registers so that hazards are common
   function automatic logic [31:0] rand_instr();
      logic [31:0] w;
      w = $urandom();
      if ($urandom_range(0, 9) == 0)
         return w;
      case ($urandom_range(0, 12))
         0:  w[6:0] = OP_LUI;
         1:  w[6:0] = OP_AUIPC;
         2:  w[6:0] = OP_JAL;
         3:  w[6:0] = OP_BRANCH;
         4:  w[6:0] = OP_JALR;
         5:  w[6:0] = OP_OPIMM;
         6:  w[6:0] = OP_FENCE;
         7:  w[6:0] = OP_SYSTEM;
         8,
         11: w[6:0] = OP_LOAD;
         9:  w[6:0] = OP_OP;
         10: w[6:0] = OP_STORE;
         default: return ECALL_WORD;
      endcase
      if ($urandom_range(0, 3) != 0) begin
         w[11:7]  = 5'($urandom_range(0, 7));
         w[19:15] = 5'($urandom_range(0, 7));
         w[24:20] = 5'($urandom_range(0, 7));
      end
      return w;
   endfunction

   task automatic send_instr(input logic [31:0] w, input int want);
      want_q.insert(want_q.size(), want);
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic sender_gap();
      int n;
      if (quiet || burst || $urandom_range(0, 3) != 0)
         return;
      n = $urandom_range(1, 6);
      req_tvalid <= 1'b0;
      req_tdata  <= $urandom();
      repeat (n) @(posedge clock);
   endtask

   // stop sending and wait for every outstanding response
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (emit_q.size() != 0);
   endtask

   task automatic set_forwarding(input logic on);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= on;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      n_cfg++;
   endtask

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) begin
         send_instr(rand_instr(), PREDICT);
         sender_gap();
      end
   endtask

   initial begin : rsp_side
      int n;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_ask) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_ask = 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            n = $urandom_range(1, 6);
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge clock);
         end
      end
   end

   initial begin : req_side
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;

      // history starts as two bubbles, forwarding off
      add_row(CFG_KEEP, 32'h0000_0000, 0);
      add_row(CFG_KEEP, 32'hFFFF_FFFF, 0);
      // unknown opcode writing x31 acts as a source
      add_row(CFG_KEEP, rv_word(OP_OP, 5'd1, 5'd31, 5'd0), 2);
      // unknown opcode as input reads nothing
      add_row(CFG_KEEP, rv_word(7'b1011011, 5'd0, 5'd1, 5'd1), 0);
      add_row(CFG_KEEP, ECALL_WORD, 0);
      // the bubble pattern as a real request
      add_row(CFG_KEEP, BUBBLE_WORD, 0);
      add_row(CFG_KEEP, rv_word(OP_JAL, 5'd2, 5'd0, 5'd0), 1);
      add_row(CFG_KEEP, rv_word(OP_LOAD, 5'd5, 5'd2, 5'd0), PREDICT);
      add_row(CFG_KEEP, rv_word(OP_OP, 5'd6, 5'd5, 5'd5), PREDICT);
      add_row(CFG_KEEP, rv_word(OP_LUI, 5'd7, 5'd0, 5'd0), PREDICT);
      add_row(CFG_KEEP, rv_word(OP_OPIMM, 5'd8, 5'd0, 5'd0), PREDICT);
      add_row(CFG_KEEP, rv_word(OP_BRANCH, 5'd0, 5'd0, 5'd7), PREDICT);
      // a store never counts as a writer
      add_row(CFG_KEEP, rv_word(OP_STORE, 5'd9, 5'd0, 5'd0), PREDICT);
      add_row(CFG_KEEP, rv_word(OP_OP, 5'd10, 5'd9, 5'd0), PREDICT);
      // I-type ignores its rs2 field
      add_row(CFG_KEEP, rv_word(OP_OPIMM, 5'd11, 5'd0, 5'd10), PREDICT);
      add_row(CFG_KEEP, rv_word(OP_STORE, 5'd0, 5'd0, 5'd11), PREDICT);
      add_row(CFG_KEEP, rv_word(OP_AUIPC, 5'd13, 5'd0, 5'd0), PREDICT);
      add_row(CFG_KEEP, rv_word(OP_SYSTEM, 5'd0, 5'd13, 5'd0), PREDICT);
      // forwarding: only load-use and JAL stall, older word not looked at
      add_row(CFG_ON, rv_word(OP_LOAD, 5'd14, 5'd0, 5'd0), PREDICT);
      add_row(CFG_KEEP, rv_word(OP_OP, 5'd15, 5'd14, 5'd14), PREDICT);
      add_row(CFG_KEEP, rv_word(OP_OP, 5'd16, 5'd15, 5'd0), PREDICT);
      add_row(CFG_KEEP, rv_word(OP_LOAD, 5'd17, 5'd16, 5'd0), PREDICT);
      add_row(CFG_KEEP, rv_word(OP_OPIMM, 5'd18, 5'd0, 5'd0), PREDICT);
      add_row(CFG_KEEP, rv_word(OP_OP, 5'd19, 5'd17, 5'd0), PREDICT);
      add_row(CFG_KEEP, rv_word(OP_JAL, 5'd0, 5'd0, 5'd0), 1);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].step != CFG_KEEP)
            set_forwarding(dir_tab[i].step == CFG_ON);
         send_instr(dir_tab[i].word, dir_tab[i].want);
         sender_gap();
      end

      set_forwarding(1'b0);
      run_random(50);

      set_forwarding(1'b1);
      run_random(20);
      // long receiver stall while requests keep coming
      hold_ask = 1'b1;
      burst    = 1'b1;
      run_random(30);
      burst    = 1'b0;

      set_forwarding(1'b0);
      run_random(25);
      settle();
      run_random(25);

      quiet = 1'b1;
      set_forwarding(1'b1);
      run_random(40);

      settle();
      repeat (20) @(posedge clock);
      $display("run: %0d instructions in, %0d words out, %0d bubbles expected",
               n_req, n_rsp, n_bub);
      $display("run: %0d forwarding writes, both modes, one long output stall",
               n_cfg);
      if (errors == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

>>> filelist.f
hdl/phni_pkg.sv
hdl/phni_hazard.sv
hdl/phni_emitter.sv
hdl/pipeline_hazard_nop_inserter.sv
test/tb_top.sv
